// ----- rtl/scc_pkg.sv -----
// Shared types and constants for the strongly connected components block.
`timescale 1ns / 1ps
package scc_pkg;
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_RUN    = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RESULT_LIMIT = 16;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_ADD   = 3'd1,
        CMD_CLEAR = 3'd2,
        CMD_START = 3'd3,
        CMD_STEP  = 3'd4
    } cmd_t;

    typedef struct packed {
        logic done;
    } status_t;
endpackage

// ----- rtl/scc_datapath.sv -----
// Datapath: adjacency matrix, walk stack, finish order, labels and the search engine.
`timescale 1ns / 1ps
module scc_datapath #(
    parameter int MAX_VERTICES = 16,
    parameter int VW = $clog2(MAX_VERTICES),
    parameter int CW = VW + 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scc_pkg::cmd_t        cmd,
    input  logic [CW-1:0]        n,
    input  logic [3:0]           src,
    input  logic [3:0]           dst,
    input  logic [VW-1:0]        rd_vertex,
    output logic [3:0]           rd_label,
    output scc_pkg::status_t     status
);
    logic [MAX_VERTICES-1:0] adj_reg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [VW-1:0] stack_reg [MAX_VERTICES];
    logic [CW-1:0] scan_reg  [MAX_VERTICES];
    logic [VW-1:0] order_reg [MAX_VERTICES];
    logic [3:0]    label_reg [MAX_VERTICES];
    logic [CW-1:0] top_reg;       // stack depth (0 = empty)
    logic [CW-1:0] fcount_reg;
    logic [CW-1:0] idx_reg;       // root scan index / finish-order cursor
    logic [3:0]    ccount_reg;
    logic          pass2_reg;
    logic          done_reg;

    logic [VW-1:0] v_top;
    logic [CW-1:0] w_pos;
    logic [VW-1:0] w_idx;
    logic          edge_bit;
    logic [VW-1:0] root_v;
    logic [VW-1:0] src_idx;
    logic [VW-1:0] dst_idx;
    logic          edge_ok;

    assign v_top    = stack_reg[top_reg[VW-1:0] - VW'(1)];
    assign w_pos    = scan_reg[top_reg[VW-1:0] - VW'(1)];
    assign w_idx    = w_pos[VW-1:0];
    assign edge_bit = pass2_reg ? adj_reg[w_idx][v_top] : adj_reg[v_top][w_idx];
    assign root_v   = pass2_reg ? order_reg[idx_reg[VW-1:0] - VW'(1)] : idx_reg[VW-1:0];
    assign rd_label = label_reg[rd_vertex];
    assign status.done = done_reg;

    // Range check on the full field width, before it is cut to an index.
    assign src_idx = VW'(src);
    assign dst_idx = VW'(dst);
    assign edge_ok = (32'(src) < 32'(n)) && (32'(dst) < 32'(n));

    // One scan position examined per cycle while walking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
                adj_reg[i] <= '0;
            visited_reg <= '0;
            top_reg     <= '0;
            fcount_reg  <= '0;
            idx_reg     <= '0;
            ccount_reg  <= '0;
            pass2_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            case (cmd)
                scc_pkg::CMD_ADD:
                begin
                    if (edge_ok)
                        adj_reg[src_idx][dst_idx] <= 1'b1;
                end
                scc_pkg::CMD_CLEAR:
                begin
                    for (int i = 0; i < MAX_VERTICES; i++)
                        adj_reg[i] <= '0;
                end
                scc_pkg::CMD_START:
                begin
                    visited_reg <= '0;
                    top_reg     <= '0;
                    fcount_reg  <= '0;
                    idx_reg     <= '0;
                    ccount_reg  <= '0;
                    pass2_reg   <= 1'b0;
                    done_reg    <= 1'b0;
                end
                scc_pkg::CMD_STEP:
                begin
                    if (top_reg != '0)
                    begin
                        if (w_pos >= n)
                        begin
                            if (!pass2_reg)
                            begin
                                order_reg[fcount_reg[VW-1:0]] <= v_top;
                                fcount_reg <= fcount_reg + CW'(1);
                            end
                            top_reg <= top_reg - CW'(1);
                            if (top_reg == CW'(1) && pass2_reg)
                                ccount_reg <= ccount_reg + 4'd1;
                        end
                        else if (edge_bit && !visited_reg[w_idx])
                        begin
                            scan_reg[top_reg[VW-1:0] - VW'(1)] <= w_pos + CW'(1);
                            stack_reg[top_reg[VW-1:0]] <= w_idx;
                            scan_reg[top_reg[VW-1:0]]  <= '0;
                            visited_reg[w_idx] <= 1'b1;
                            if (pass2_reg)
                                label_reg[w_idx] <= ccount_reg;
                            top_reg <= top_reg + CW'(1);
                        end
                        else
                            scan_reg[top_reg[VW-1:0] - VW'(1)] <= w_pos + CW'(1);
                    end
                    else if (!pass2_reg)
                    begin
                        if (idx_reg >= n)
                        begin
                            pass2_reg   <= 1'b1;
                            visited_reg <= '0;
                            idx_reg     <= fcount_reg;
                        end
                        else
                        begin
                            if (!visited_reg[root_v])
                            begin
                                stack_reg[0] <= root_v;
                                scan_reg[0]  <= '0;
                                visited_reg[root_v] <= 1'b1;
                                top_reg <= CW'(1);
                            end
                            idx_reg <= idx_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        if (idx_reg == '0)
                            done_reg <= 1'b1;
                        else
                        begin
                            if (!visited_reg[root_v])
                            begin
                                stack_reg[0] <= root_v;
                                scan_reg[0]  <= '0;
                                visited_reg[root_v] <= 1'b1;
                                label_reg[root_v] <= ccount_reg;
                                top_reg <= CW'(1);
                            end
                            idx_reg <= idx_reg - CW'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule

// ----- rtl/scc_ctrl.sv -----
// Controller: takes transactions, sequences the search and streams results.
`timescale 1ns / 1ps
module scc_ctrl #(
    parameter int MAX_VERTICES = 16,
    parameter int VW = $clog2(MAX_VERTICES),
    parameter int CW = VW + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       opcode,
    input  logic [CW-1:0]    n,
    input  scc_pkg::status_t status,
    output scc_pkg::cmd_t    cmd,
    output logic [VW-1:0]    rd_vertex,
    input  logic [3:0]       rd_label,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [3:0]       vertex_id,
    output logic [3:0]       component_id,
    output logic             last
);
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_WALK  = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] k_reg, k_next;
    logic          ov_reg, ov_next;
    logic [3:0]    vid_reg, vid_next, cid_reg, cid_next;
    logic          last_reg, last_next;
    logic          load;

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = ov_reg;
    assign vertex_id    = vid_reg;
    assign component_id = cid_reg;
    assign last         = last_reg;
    assign rd_vertex    = k_reg[VW-1:0];
    assign load         = (state_reg == S_EMIT) && (!ov_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        ov_next    = ov_reg && !out_ready;
        vid_next   = vid_reg;
        cid_next   = cid_reg;
        last_next  = last_reg;
        cmd        = scc_pkg::CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (opcode)
                        scc_pkg::OP_ADD:   cmd = scc_pkg::CMD_ADD;
                        scc_pkg::OP_CLEAR: cmd = scc_pkg::CMD_CLEAR;
                        scc_pkg::OP_RUN:   state_next = S_START;
                        default:           cmd = scc_pkg::CMD_NONE;
                    endcase
                end
            end
            S_START:
            begin
                cmd        = scc_pkg::CMD_START;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                cmd = scc_pkg::CMD_STEP;
                if (status.done)
                begin
                    cmd        = scc_pkg::CMD_NONE;
                    k_next     = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (load)
                begin
                    ov_next   = 1'b1;
                    vid_next  = 4'(k_reg);
                    cid_next  = rd_label;
                    last_next = (k_reg + CW'(1) == n);
                    k_next    = k_reg + CW'(1);
                    if (k_reg + CW'(1) == n)
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vid_reg  <= vid_next;
        cid_reg  <= cid_next;
        last_reg <= last_next;
    end
endmodule

// ----- rtl/strongly_connected_components.sv -----
// Top level of the strongly connected components block.
`timescale 1ns / 1ps
// Kosaraju strongly connected components over an adjacency bit matrix of up to
// MAX_VERTICES vertices (at most 16 reported). Opcode 0 adds an edge (edges
// naming a vertex at or beyond the active vertex count are dropped), opcode 2
// clears the graph, opcode 3 is ignored. Opcode 1 runs the search:
// a depth-first walk records finish order, then a walk of the transposed matrix
// in reverse finish order labels components in discovery order. The walk
// engine examines one matrix bit per cycle. For n active vertices a run is
// followed by n result transactions in ascending vertex order with last set on
// the final one. A single result register holds each result transaction until
// it is taken; a stall on the output stalls the result stream, and no input
// is taken during a run or before its final result is loaded. vertex_count
// must be written only while the block is idle; the block does not enforce
// this. Zero acts as one and values above the vertex limit are clamped.
module strongly_connected_components #(
    parameter int MAX_VERTICES = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] opcode,
    input  logic [3:0] src_vertex,
    input  logic [3:0] dst_vertex,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] vertex_id,
    output logic [3:0] component_id,
    output logic       last
);
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = VW + 1;
    localparam int LIM = (MAX_VERTICES < scc_pkg::RESULT_LIMIT) ?
                         MAX_VERTICES : scc_pkg::RESULT_LIMIT;

    logic [4:0]       vcount_reg;
    logic [CW-1:0]    n;
    scc_pkg::cmd_t    cmd;
    scc_pkg::status_t status;
    logic [VW-1:0]    rd_vertex;
    logic [3:0]       rd_label;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vcount_reg <= 5'd8;
        else if (cfg_valid)
            vcount_reg <= cfg_data;
    end

    // Active vertex count, clamped to 1..LIM.
    always_comb
    begin
        if (vcount_reg == 5'd0)
            n = CW'(1);
        else if (32'(vcount_reg) > LIM)
            n = CW'(LIM);
        else
            n = CW'(vcount_reg);
    end

    scc_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
        .n(n), .status(status), .cmd(cmd),
        .rd_vertex(rd_vertex), .rd_label(rd_label),
        .out_valid(out_valid), .out_ready(out_ready),
        .vertex_id(vertex_id), .component_id(component_id), .last(last)
    );

    scc_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .n(n),
        .src(src_vertex), .dst(dst_vertex),
        .rd_vertex(rd_vertex), .rd_label(rd_label), .status(status)
    );
endmodule

// ----- bench/scc_checker.sv -----
// Checker: watches the block's channels, predicts component labels and compares them.
`timescale 1ns / 1ps
module scc_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [4:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] opcode,
    input  logic [3:0] src_vertex,
    input  logic [3:0] dst_vertex,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [3:0] vertex_id,
    input  logic [3:0] component_id,
    input  logic       last,
    output int         fail_count,
    output int         labels_pending
);
    typedef struct packed {
        logic [3:0] vertex;
        logic [3:0] label;
        logic       last;
    } label_t;

    logic [15:0] graph [16];
    logic [4:0]  count_reg;
    label_t      label_q [$];

    function automatic int active_vertices();
        int n;
        n = count_reg;
        if (n < 1) n = 1;
        if (n > 16) n = 16;
        return n;
    endfunction

    function automatic logic edge_at(int a, int b, bit tr);
        return tr ? graph[b][a] : graph[a][b];
    endfunction

    // Iterative walks, one per pass; pass two labels vertices.
    task automatic predict_components();
        int n, top, v, w, fcnt, comp, i;
        logic [15:0] seen;
        int order [16];
        int stk [16];
        int pos [16];
        int lab [16];
        bit tr;
        n = active_vertices();
        fcnt = 0;
        comp = 0;
        for (int p = 0; p < 2; p++)
        begin
            tr = (p == 1);
            seen = '0;
            for (int r = 0; r < (tr ? fcnt : n); r++)
            begin
                i = tr ? order[fcnt - 1 - r] : r;
                if (!seen[i])
                begin
                    top = 0;
                    stk[0] = i;
                    pos[0] = 0;
                    seen[i] = 1'b1;
                    if (tr) lab[i] = comp;
                    while (top >= 0)
                    begin
                        v = stk[top];
                        w = pos[top];
                        while (w < n && (!edge_at(v, w, tr) || seen[w])) w++;
                        if (w < n && top + 1 < 16)
                        begin
                            pos[top] = w + 1;
                            top++;
                            stk[top] = w;
                            pos[top] = 0;
                            seen[w] = 1'b1;
                            if (tr) lab[w] = comp;
                        end
                        else
                        begin
                            if (!tr && fcnt < 16)
                            begin
                                order[fcnt] = v;
                                fcnt++;
                            end
                            top--;
                        end
                    end
                    if (tr) comp++;
                end
            end
        end
        for (int k = 0; k < n; k++)
            label_q.push_back('{vertex: 4'(k), label: 4'(lab[k]), last: (k + 1 == n)});
    endtask

    assign labels_pending = label_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++) graph[i] <= '0;
            count_reg  <= 5'd8;
            fail_count <= 0;
            label_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready) count_reg <= cfg_data;
            if (out_valid && out_ready)
            begin
                if (label_q.size() == 0)
                begin
                    $display("%0t: unexpected result expected none actual v=%0d c=%0d l=%0d",
                             $time, vertex_id, component_id, last);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (label_q[0] !== {vertex_id, component_id, last})
                    begin
                        $display({"%0t: result expected v=%0d c=%0d l=%0d",
                                  " actual v=%0d c=%0d l=%0d"},
                                 $time, label_q[0].vertex, label_q[0].label, label_q[0].last,
                                 vertex_id, component_id, last);
                        fail_count <= fail_count + 1;
                    end
                    void'(label_q.pop_front());
                end
            end
            if (in_valid && in_ready)
            begin
                if (opcode == scc_pkg::OP_ADD)
                begin
                    if (src_vertex < active_vertices() && dst_vertex < active_vertices())
                        graph[src_vertex][dst_vertex] <= 1'b1;
                end
                else if (opcode == scc_pkg::OP_CLEAR)
                begin
                    for (int i = 0; i < 16; i++) graph[i] <= '0;
                end
                else if (opcode == scc_pkg::OP_RUN)
                    predict_components();
            end
        end
    end
endmodule

// ----- bench/tb.sv -----
// Testbench top: stimulus, configuration phases and verdict for the SCC block.
`timescale 1ns / 1ps
module tb;
    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [4:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] opcode;
    logic [3:0] src_vertex;
    logic [3:0] dst_vertex;
    logic       out_valid;
    logic       out_ready;
    logic [3:0] vertex_id;
    logic [3:0] component_id;
    logic       last;
    int         fail_count;
    int         labels_pending;

    // Bench controls
    int  cycle_count;
    bit  quiet_tail;     // no idling on either side near the end
    bit  hold_results;   // long receiver hold-off requested
    int  graph_size;     // mirror of the register, for stimulus shaping

    localparam int CYCLE_LIMIT = 3000000;

    strongly_connected_components #(.MAX_VERTICES(16)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .src_vertex(src_vertex), .dst_vertex(dst_vertex),
        .out_valid(out_valid), .out_ready(out_ready),
        .vertex_id(vertex_id), .component_id(component_id), .last(last)
    );

    scc_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .src_vertex(src_vertex), .dst_vertex(dst_vertex),
        .out_valid(out_valid), .out_ready(out_ready),
        .vertex_id(vertex_id), .component_id(component_id), .last(last),
        .fail_count(fail_count), .labels_pending(labels_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a hung block ends the run as a failure.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("strongly_connected_components: mismatch");
                $finish;
            end
        end
    end

    // Receiver: random ready bursts, plus one long hold-off counted here.
    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_results)
            begin
                out_ready <= 1'b0;
                for (int i = 0; i < 3000; i++) @(posedge clk);
                hold_results = 1'b0;
            end
            n = $urandom_range(1, 14);
            out_ready <= quiet_tail || $urandom_range(0, 1);
            repeat (n) @(posedge clk);
        end
    end

    // One input transaction; valid holds until the handshake.
    task automatic send_item(input logic [1:0] op, input logic [3:0] s, input logic [3:0] d);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        src_vertex <= s;
        dst_vertex <= d;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (labels_pending != 0) @(posedge clk);
        // edge and clear items leave nothing to wait on; give the engine time
        repeat (600) @(posedge clk);
    endtask

    task automatic write_count(input logic [4:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        graph_size = (value == 0) ? 1 : (value > 16 ? 16 : value);
    endtask

    // Random graph: a clear, random edges, then a run.
    task automatic random_graph(input int edges);
        logic [3:0] a, b;
        logic [1:0] op;
        send_item(scc_pkg::OP_CLEAR, 4'($urandom), 4'($urandom));
        for (int e = 0; e < edges; e++)
        begin
            a = 4'($urandom_range(0, graph_size - 1));
            b = 4'($urandom_range(0, graph_size - 1));
            op = scc_pkg::OP_ADD;
            // some noise: out-of-range edges, unused opcode
            if ($urandom_range(0, 9) == 0) a = 4'($urandom);
            if ($urandom_range(0, 9) == 0) b = 4'($urandom);
            if ($urandom_range(0, 29) == 0) op = scc_pkg::OP_UNUSED;
            send_item(op, a, b);
        end
        send_item(scc_pkg::OP_RUN, 4'($urandom), 4'($urandom));
    endtask

    initial
    begin
        int sizes [6];
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        opcode       = scc_pkg::OP_ADD;
        src_vertex   = '0;
        dst_vertex   = '0;
        quiet_tail   = 1'b0;
        hold_results = 1'b0;
        graph_size   = 8;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty graph at reset count, a ring, self loop, duplicates.
        send_item(scc_pkg::OP_RUN, 4'd0, 4'd0);
        send_item(scc_pkg::OP_ADD, 4'd0, 4'd1);
        send_item(scc_pkg::OP_ADD, 4'd1, 4'd2);
        send_item(scc_pkg::OP_ADD, 4'd2, 4'd0);
        send_item(scc_pkg::OP_ADD, 4'd2, 4'd0);
        send_item(scc_pkg::OP_ADD, 4'd5, 4'd5);
        send_item(scc_pkg::OP_ADD, 4'd3, 4'd15);  // beyond count: dropped
        send_item(scc_pkg::OP_ADD, 4'd15, 4'd3);
        send_item(scc_pkg::OP_UNUSED, 4'd7, 4'd6);
        send_item(scc_pkg::OP_ADD, 4'd7, 4'd6);
        send_item(scc_pkg::OP_RUN, 4'd15, 4'd15);
        // Count 16, full ring 15->0, then stale edges after shrinking
        write_count(5'd16);
        for (int v = 0; v < 16; v++)
            send_item(scc_pkg::OP_ADD, 4'(v), 4'((v + 1) % 16));
        send_item(scc_pkg::OP_RUN, 4'd0, 4'd0);
        write_count(5'd4);
        send_item(scc_pkg::OP_RUN, 4'd0, 4'd0);
        write_count(5'd0);
        send_item(scc_pkg::OP_RUN, 4'd0, 4'd0);
        write_count(5'd31);
        send_item(scc_pkg::OP_CLEAR, 4'd0, 4'd0);
        send_item(scc_pkg::OP_RUN, 4'd0, 4'd0);
        write_count(5'd1);
        send_item(scc_pkg::OP_ADD, 4'd0, 4'd0);
        send_item(scc_pkg::OP_RUN, 4'd0, 4'd0);

        // Random phases over several counts, the largest included.
        sizes = '{2, 16, 5, 9, 3, 12};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_count(5'(sizes[ph]));
            for (int g = 0; g < 7; g++)
            begin
                if (ph == 1 && g == 2)
                begin
                    // long receiver stall while runs keep coming
                    hold_results = 1'b1;
                    send_item(scc_pkg::OP_RUN, 4'd0, 4'd0);
                    send_item(scc_pkg::OP_RUN, 4'd0, 4'd0);
                    send_item(scc_pkg::OP_RUN, 4'd0, 4'd0);
                end
                if (ph == 3 && g == 3)
                    wait_drained();     // sender pause until all results are in
                if (ph == 5 && g == 4)
                    quiet_tail = 1'b1;
                random_graph($urandom_range(0, 2 * graph_size));
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("strongly_connected_components: match");
        else
            $display("strongly_connected_components: mismatch");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/scc_pkg.sv
rtl/scc_datapath.sv
rtl/scc_ctrl.sv
rtl/strongly_connected_components.sv
bench/scc_checker.sv
bench/tb.sv
